FILE: rtl/h2r_pkg.sv
// package for the hsv to rgb converter: default widths and hue sector codes
// no dependencies; imported by h2r_div_cmax and hsv_to_rgb_converter_top
package h2r_pkg;

  // default field widths
  localparam int HUE_BITS_DEF     = 16;
  localparam int CHANNEL_BITS_DEF = 8;

  // hue sector, one sixth of a turn each
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

FILE: rtl/hsv_to_rgb_converter_top.sv
// hsv to rgb pixel converter, five-stage pipeline with stream handshakes
// depends on h2r_pkg and h2r_div_cmax
//
// Converts one HSV pixel to one RGB pixel per request and keeps no state
// between pixels. A new pixel is taken every clock cycle while the output
// side keeps up. The edge that takes a request already loads the first of five
// register stages, and the result is offered from the last of them, the output
// register. The stages are: hue sector and s*v, then s*v*f, then the
// rounded level numerators, then three divide-by-cmax units, then the sector
// select into the output register. Each stage holds its own valid bit and
// loads whenever it is empty or the stage after it has room, so a stall on
// the output fills empty stages first and loses nothing. Zero saturation
// gives grey (r = g = b = brightness). Reset clears the valid bits only.
module hsv_to_rgb_converter_top #(
  parameter int HUE_BITS     = h2r_pkg::HUE_BITS_DEF,
  parameter int CHANNEL_BITS = h2r_pkg::CHANNEL_BITS_DEF,
  localparam int IN_W  = ((HUE_BITS + 2*CHANNEL_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3*CHANNEL_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // hue, saturation, brightness (low bit up)
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // red, green, blue (low bit up), zero pad
);
  import h2r_pkg::*;

  localparam int H  = HUE_BITS;
  localparam int N  = CHANNEL_BITS;
  localparam int VW = 2*N;        // products of two channels
  localparam int FW = 2*N + H;    // s*v*f
  localparam int QW = 2*N + H + 1;
  localparam logic [N-1:0]  CMAX   = '1;
  localparam logic [VW-1:0] P_HALF = VW'(CMAX >> 1);
  localparam logic [QW-1:0] Q_HALF = QW'(CMAX) << (H-1);

  // input fields
  logic [H-1:0] hue;
  logic [N-1:0] sat;
  logic [N-1:0] bri;
  assign hue = in_tdata[H-1:0];
  assign sat = in_tdata[H +: N];
  assign bri = in_tdata[H+N +: N];

  // stage valid bits and room
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || out_tready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // stage 1: hue*6 into sector and fraction, s*v
  logic [H+2:0]  h6;
  sector_t       s1_sec_nxt, s1_sec_r;
  logic [H-1:0]  s1_f_r;
  logic [VW-1:0] s1_vs_nxt, s1_vs_r;
  logic [N-1:0]  s1_v_r;

  always_comb begin
    h6         = ((H+3)'(hue) << 2) + ((H+3)'(hue) << 1);
    s1_sec_nxt = sector_t'(h6[H+2:H]);
    s1_vs_nxt  = VW'(bri) * VW'(sat);
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_sec_r <= s1_sec_nxt;
      s1_f_r   <= h6[H-1:0];
      s1_vs_r  <= s1_vs_nxt;
      s1_v_r   <= bri;
    end
  end

  // stage 2: s*v*f, v*cmax and v*(cmax - s)
  sector_t       s2_sec_r;
  logic [N-1:0]  s2_v_r;
  logic [FW-1:0] s2_vsf_nxt, s2_vsf_r;
  logic [VW-1:0] s2_vc_nxt, s2_vc_r;
  logic [VW-1:0] s2_vcs_nxt, s2_vcs_r;

  always_comb begin
    s2_vsf_nxt = FW'(s1_vs_r) * FW'(s1_f_r);
    s2_vc_nxt  = (VW'(s1_v_r) << N) - VW'(s1_v_r);
    s2_vcs_nxt = s2_vc_nxt - s1_vs_r;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_sec_r <= s1_sec_r;
      s2_v_r   <= s1_v_r;
      s2_vsf_r <= s2_vsf_nxt;
      s2_vc_r  <= s2_vc_nxt;
      s2_vcs_r <= s2_vcs_nxt;
    end
  end

  // stage 3: rounded numerators, q and t pre-divided by the hue unit
  sector_t       s3_sec_r;
  logic [N-1:0]  s3_v_r;
  logic [QW-1:0] q_num, t_num;
  logic [VW-1:0] s3_p_nxt, s3_p_r;
  logic [VW-1:0] s3_q_r, s3_t_r;

  always_comb begin
    s3_p_nxt = s2_vcs_r + P_HALF;
    q_num    = (QW'(s2_vc_r) << H) - QW'(s2_vsf_r) + Q_HALF;
    t_num    = (QW'(s2_vcs_r) << H) + QW'(s2_vsf_r) + Q_HALF;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_sec_r <= s2_sec_r;
      s3_v_r   <= s2_v_r;
      s3_p_r   <= s3_p_nxt;
      s3_q_r   <= q_num[H +: VW];
      s3_t_r   <= t_num[H +: VW];
    end
  end

  // stage 4: divide the three levels by cmax
  sector_t      s4_sec_r;
  logic [N-1:0] s4_v_r;
  logic [N-1:0] lvl_p, lvl_q, lvl_t;

  h2r_div_cmax #(.CHANNEL_BITS(N)) u_div_p (
    .clk(clk), .en(rdy4), .num(s3_p_r), .quo_r(lvl_p)
  );
  h2r_div_cmax #(.CHANNEL_BITS(N)) u_div_q (
    .clk(clk), .en(rdy4), .num(s3_q_r), .quo_r(lvl_q)
  );
  h2r_div_cmax #(.CHANNEL_BITS(N)) u_div_t (
    .clk(clk), .en(rdy4), .num(s3_t_r), .quo_r(lvl_t)
  );

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_sec_r <= s3_sec_r;
      s4_v_r   <= s3_v_r;
    end
  end

  // stage 5: pick channels per sector into the output register
  logic [N-1:0] red_nxt, grn_nxt, blu_nxt;
  logic [N-1:0] red_r, grn_r, blu_r;

  always_comb begin
    case (s4_sec_r)
      SEC_RED_YEL: begin
        red_nxt = s4_v_r; grn_nxt = lvl_t;  blu_nxt = lvl_p;
      end
      SEC_YEL_GRN: begin
        red_nxt = lvl_q;  grn_nxt = s4_v_r; blu_nxt = lvl_p;
      end
      SEC_GRN_CYN: begin
        red_nxt = lvl_p;  grn_nxt = s4_v_r; blu_nxt = lvl_t;
      end
      SEC_CYN_BLU: begin
        red_nxt = lvl_p;  grn_nxt = lvl_q;  blu_nxt = s4_v_r;
      end
      SEC_BLU_MAG: begin
        red_nxt = lvl_t;  grn_nxt = lvl_p;  blu_nxt = s4_v_r;
      end
      default: begin
        red_nxt = s4_v_r; grn_nxt = lvl_p;  blu_nxt = lvl_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      red_r <= red_nxt;
      grn_r <= grn_nxt;
      blu_r <= blu_nxt;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = OUT_W'({blu_r, grn_r, red_r});

endmodule

FILE: rtl/h2r_div_cmax.sv
// registered divide by the all-ones channel code (2^N - 1)
// depends on h2r_pkg for the default channel width
module h2r_div_cmax #(
  parameter int CHANNEL_BITS = h2r_pkg::CHANNEL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [2*CHANNEL_BITS-1:0]   num,  // must stay below cmax*(cmax+1)
  output logic [CHANNEL_BITS-1:0]     quo_r
);
  import h2r_pkg::*;

  localparam int N = CHANNEL_BITS;
  localparam logic [N:0] CMAX1 = {1'b0, {N{1'b1}}};
  localparam logic [N:0] CMAX2 = {{N{1'b1}}, 1'b0};

  logic [N:0]   q0;
  logic [N:0]   rem;
  logic [N:0]   quo_full;
  logic [N-1:0] quo_nxt;

  // x = hi*2^N + lo, so x - hi*cmax = lo + hi; fix up with at most two steps
  always_comb begin
    q0  = {1'b0, num[2*N-1:N]};
    rem = {1'b0, num[N-1:0]} + q0;
    if (rem >= CMAX2) begin
      quo_full = q0 + (N+1)'(2);
    end else if (rem >= CMAX1) begin
      quo_full = q0 + (N+1)'(1);
    end else begin
      quo_full = q0;
    end
    quo_nxt = quo_full[N-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

endmodule
